[design/ipk_pkg.sv]
// shared types and constants for the iambic paddle keyer
package ipk_pkg;

    localparam int SPEED_BITS_DEFAULT = 8;
    localparam int SCALE_BITS         = 6;
    localparam int DAH_BITS           = 3;
    localparam int CFG_INDEX_BITS     = 1;

    localparam logic [SCALE_BITS-1:0] UNIT_SCALE_RESET = 6'd20;
    localparam logic [DAH_BITS-1:0]   DAH_LENGTH_RESET = 3'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNIT_SCALE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DAH_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DIT  = 2'd1,
        KIND_DAH  = 2'd2
    } element_kind_t;

    typedef struct packed {
        logic key;
        logic tone;
    } ipk_result_t;

endpackage

[design/ipk_keyer.sv]
// keyer state, tick counter and per-tick keying step
module ipk_keyer
    import ipk_pkg::*;
#(
    parameter int CNT_W = SPEED_BITS_DEFAULT + SCALE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                dit,
    input  logic                dah,
    input  logic [CNT_W-1:0]    threshold,
    input  logic [DAH_BITS-1:0] dah_length,
    output ipk_result_t         result
);

    logic [CNT_W-1:0]    tick_count_reg, tick_count_next;
    element_kind_t       kind_reg, kind_next;
    logic [DAH_BITS-1:0] dah_units_reg, dah_units_next;
    logic                done_reg, done_next;
    logic                key_reg, key_next;
    logic                tone_reg, tone_next;
    logic                fire;
    element_kind_t       kind_sel;

    always_comb
    begin
        fire            = (tick_count_reg >= threshold);
        tick_count_next = fire ? '0 : tick_count_reg + CNT_W'(1);
        kind_next       = kind_reg;
        dah_units_next  = dah_units_reg;
        done_next       = done_reg;
        key_next        = key_reg;
        tone_next       = tone_reg ^ key_reg;
        kind_sel        = kind_reg;

        if (fire)
        begin
            if (done_reg)
            begin
                if (dit && dah)
                    kind_sel = (kind_reg == KIND_DIT) ? KIND_DAH : KIND_DIT;
                else if (dit)
                    kind_sel = KIND_DIT;
                else if (dah)
                    kind_sel = KIND_DAH;
                else
                    kind_sel = KIND_NONE;
            end
            kind_next = kind_sel;
            unique case (kind_sel)
                KIND_DAH:
                begin
                    if (dah_units_reg < dah_length)
                    begin
                        done_next      = 1'b0;
                        dah_units_next = dah_units_reg + DAH_BITS'(1);
                        key_next       = 1'b1;
                    end
                    else
                    begin
                        dah_units_next = '0;
                        key_next       = 1'b0;
                        tone_next      = 1'b0;
                        done_next      = 1'b1;
                    end
                end
                KIND_DIT:
                begin
                    done_next = key_reg;
                    key_next  = ~key_reg;
                end
                default:
                begin
                    key_next  = 1'b0;
                    tone_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end

        // both paddles released
        if (!dit && !dah)
        begin
            key_next       = 1'b0;
            tone_next      = 1'b0;
            dah_units_next = '0;
            done_next      = 1'b1;
            kind_next      = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            kind_reg       <= KIND_NONE;
            dah_units_reg  <= '0;
            done_reg       <= 1'b1;
            key_reg        <= 1'b0;
            tone_reg       <= 1'b0;
        end
        else if (advance)
        begin
            tick_count_reg <= tick_count_next;
            kind_reg       <= kind_next;
            dah_units_reg  <= dah_units_next;
            done_reg       <= done_next;
            key_reg        <= key_next;
            tone_reg       <= tone_next;
        end
    end

    assign result.key  = key_next;
    assign result.tone = tone_next;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        key_reg |-> (kind_reg != KIND_NONE))
        else $error("key on with no element");

    assert property (@(posedge clk) disable iff (!rst_n)
        (dah_units_reg != '0) |-> (kind_reg == KIND_DAH))
        else $error("dah units counting outside a dah");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !dit && !dah |=> !key_reg && !tone_reg && done_reg)
        else $error("release did not clear the keyer");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tick_count_reg) && $stable(key_reg) && $stable(tone_reg))
        else $error("keyer state moved without a beat");
`endif

endmodule

[design/iambic_paddle_keyer_unit.sv]
// top level of the iambic paddle keyer: config registers, input and result stages
// One tick beat can be taken every clock; its result goes through the input stage and
// the result register. The input stage registers the paddles and the unit threshold
// (speed_code times unit_scale, one small multiply); the next stage compares the tick
// counter, runs the keying step and loads the result register. A stalled result holds
// the input stage, which then stalls the next tick. unit_scale and dah_length are
// written through the config port and should change only when idle.
module iambic_paddle_keyer_unit
    import ipk_pkg::*;
#(
    parameter int SPEED_BITS = SPEED_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      dit_paddle,
    input  logic                      dah_paddle,
    input  logic [SPEED_BITS-1:0]     speed_code,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      key_out,
    output logic                      tone_out,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SCALE_BITS-1:0]     cfg_data
);

    localparam int CNT_W = SPEED_BITS + SCALE_BITS;

    logic [SCALE_BITS-1:0] unit_scale_reg;
    logic [DAH_BITS-1:0]   dah_length_reg;
    logic                  s1_valid_reg;
    logic                  s1_dit_reg;
    logic                  s1_dah_reg;
    logic [CNT_W-1:0]      s1_thr_reg;
    logic                  out_valid_reg;
    ipk_result_t           out_reg;
    ipk_result_t           step_result;
    logic                  advance;
    logic                  in_take;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_scale_reg <= UNIT_SCALE_RESET;
            dah_length_reg <= DAH_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_UNIT_SCALE: unit_scale_reg <= cfg_data;
                CFG_DAH_LENGTH: dah_length_reg <= cfg_data[DAH_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_dit_reg <= dit_paddle;
            s1_dah_reg <= dah_paddle;
            s1_thr_reg <= CNT_W'(speed_code) * CNT_W'(unit_scale_reg);
        end
    end

    ipk_keyer #(
        .CNT_W (CNT_W)
    ) u_keyer (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .dit        (s1_dit_reg),
        .dah        (s1_dah_reg),
        .threshold  (s1_thr_reg),
        .dah_length (dah_length_reg),
        .result     (step_result)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign key_out   = out_reg.key;
    assign tone_out  = out_reg.tone;

endmodule
